// File: design/svm_pkg.sv
// Shared types, constants and helpers of the stack machine execute unit.
`default_nettype none
package svm_pkg;

   localparam int MEM_WORDS_DEFAULT   = 32768;
   localparam int STACK_DEPTH_DEFAULT = 256;

   localparam logic [15:0] OP_REG_BASE = 16'd32768;
   localparam logic [15:0] OP_REG_LAST = 16'd32775;
   localparam logic [14:0] WORD_MASK   = 15'd32767;

   // Instruction codes.
   localparam logic [4:0] CMD_SET  = 5'd0;
   localparam logic [4:0] CMD_PUSH = 5'd1;
   localparam logic [4:0] CMD_POP  = 5'd2;
   localparam logic [4:0] CMD_EQ   = 5'd3;
   localparam logic [4:0] CMD_GT   = 5'd4;
   localparam logic [4:0] CMD_JMP  = 5'd5;
   localparam logic [4:0] CMD_JT   = 5'd6;
   localparam logic [4:0] CMD_JF   = 5'd7;
   localparam logic [4:0] CMD_ADD  = 5'd8;
   localparam logic [4:0] CMD_MULT = 5'd9;
   localparam logic [4:0] CMD_MOD  = 5'd10;
   localparam logic [4:0] CMD_AND  = 5'd11;
   localparam logic [4:0] CMD_OR   = 5'd12;
   localparam logic [4:0] CMD_NOT  = 5'd13;
   localparam logic [4:0] CMD_RMEM = 5'd14;
   localparam logic [4:0] CMD_WMEM = 5'd15;
   localparam logic [4:0] CMD_CALL = 5'd16;
   localparam logic [4:0] CMD_RET  = 5'd17;
   localparam logic [4:0] CMD_OUT  = 5'd18;
   localparam logic [4:0] CMD_IN   = 5'd19;

   // Status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_OP    = 3'd1;
   localparam logic [2:0] ST_STK_EMPTY = 3'd2;
   localparam logic [2:0] ST_STK_FULL  = 3'd3;
   localparam logic [2:0] ST_DIV_ZERO  = 3'd4;

   // Datapath result selects for the destination write.
   localparam logic [2:0] RES_ALU   = 3'd0;
   localparam logic [2:0] RES_MOD   = 3'd1;
   localparam logic [2:0] RES_STACK = 3'd2;
   localparam logic [2:0] RES_MEM   = 3'd3;
   localparam logic [2:0] RES_CHAR  = 3'd4;
   localparam logic [2:0] RES_VB    = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // capture the request beat
      logic       op_rd;      // latch operand values from the register file
      logic       mem_rd;     // issue memory read at value b
      logic       stk_rd;     // issue stack read at sp-1
      logic       mod_start;  // start the divider
      logic       wr_dest;    // write result to the destination
      logic [2:0] res_sel;    // which result is written
      logic       mem_wr_a;   // wmem: write memory at value a with value b
      logic       stk_push;   // push a value onto the stack
      logic       push_ra;    // push the return address instead of value a
      logic       stk_pop;    // decrement the stack pointer
   } svm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [4:0]  cmd;
      logic        bad_a;
      logic        bad_b;
      logic        bad_c;
      logic        a_is_reg;
      logic        stk_empty;
      logic        stk_full;
      logic        vc_zero;
      logic        va_nonzero;
      logic        mod_done;
      logic [14:0] va_low;
      logic [14:0] vb_low;
      logic [14:0] stk_low;
   } svm_stat_type;

   function automatic logic is_bad(input logic [15:0] x);
      return x > OP_REG_LAST;
   endfunction

endpackage
`default_nettype wire

// File: design/stack_vm_instruction_execute.sv
// Top level of the stack machine execute unit.
//   Channel | Dir | Beat contents
//   req_    | in  | cmd, operand_a/b/c, return_address, input_char
//   rsp_    | out | status, redirect, redirect_target, char_valid, char_out
// One instruction at a time. Each passes the read and execute states; pop,
// ret and rmem also pass the writeback state, and mod waits for the bit-serial divider.
// A new beat is taken once the previous result has left the output register.
// Reset clears the registers and stack pointer; memory and stack contents
// are undefined until written.
`default_nettype none
module stack_vm_instruction_execute
   import svm_pkg::*;
#(
   parameter int MEM_WORDS   = MEM_WORDS_DEFAULT,
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[4:0], operand_a[20:5], operand_b[36:21], operand_c[52:37],
   // return_address[67:53], input_char[75:68]
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0], redirect[3], redirect_target[18:4], char_valid[19],
   // char_out[27:20]
   output logic [31:0]      rsp_tdata
);

   svm_cmd_type  cmd;
   svm_stat_type stat;

   svm_control u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd_o      (cmd),
      .stat_i     (stat)
   );

   svm_datapath #(
      .MEM_WORDS   (MEM_WORDS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd_i   (cmd),
      .req_cmd (req_tdata[4:0]),
      .req_a   (req_tdata[20:5]),
      .req_b   (req_tdata[36:21]),
      .req_c   (req_tdata[52:37]),
      .req_ra  (req_tdata[67:53]),
      .req_ch  (req_tdata[75:68]),
      .stat_o  (stat)
   );

endmodule
`default_nettype wire

// File: design/svm_mod_unit.sv
// Bit-serial restoring divider that gives the remainder of a 16-bit division.
`default_nettype none
module svm_mod_unit
   import svm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [15:0]      remainder
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   // One quotient bit per cycle while the divider is busy.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[15]} - {1'b0, div_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[14:0], 1'b0};
         if (!trial[16]) begin
            rem_in = trial[15:0];
         end else begin
            rem_in = {rem_ff[14:0], quo_ff[15]};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: design/svm_datapath.sv
// Datapath: request capture, register file, word memory, return stack and ALU.
`default_nettype none
module svm_datapath
   import svm_pkg::*;
#(
   parameter int MEM_WORDS   = MEM_WORDS_DEFAULT,
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire svm_cmd_type  cmd_i,
   input  wire logic [4:0]   req_cmd,
   input  wire logic [15:0]  req_a,
   input  wire logic [15:0]  req_b,
   input  wire logic [15:0]  req_c,
   input  wire logic [14:0]  req_ra,
   input  wire logic [7:0]   req_ch,
   output svm_stat_type      stat_o
);

   localparam int MAW = $clog2(MEM_WORDS);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SAW = $clog2(STACK_DEPTH);

   logic [4:0]  cmd_ff;
   logic [15:0] a_ff, b_ff, c_ff;
   logic [14:0] ra_ff;
   logic [7:0]  ch_ff;
   logic [15:0] va_ff, vb_ff, vc_ff;
   logic [15:0] regs_ff [8];
   logic [15:0] mem [MEM_WORDS];
   logic [15:0] stk [STACK_DEPTH];
   logic [15:0] mem_q_ff, stk_q_ff;
   logic        mem_q_ok_ff;
   logic [SPW-1:0] sp_ff;

   logic [15:0] alu_res, res, mod_rem;
   logic        mod_done;
   logic [31:0] prod;

   // Operand value: literal or register contents.
   function automatic logic [15:0] fetch(input logic [15:0] x,
                                         input logic [15:0] r [8]);
      return (x < OP_REG_BASE) ? x : r[x[2:0]];
   endfunction

   // Capture the beat and resolve operand values.
   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         cmd_ff <= req_cmd;
         a_ff   <= req_a;
         b_ff   <= req_b;
         c_ff   <= req_c;
         ra_ff  <= req_ra;
         ch_ff  <= req_ch;
      end
      if (cmd_i.op_rd) begin
         va_ff <= fetch(a_ff, regs_ff);
         vb_ff <= fetch(b_ff, regs_ff);
         vc_ff <= fetch(c_ff, regs_ff);
      end
   end

   svm_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd_i.mod_start),
      .dividend  (vb_ff),
      .divisor   (vc_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Combinational ALU operations.
   always_comb begin
      prod = vb_ff * vc_ff;
      unique case (cmd_ff)
         CMD_EQ:   alu_res = {15'd0, vb_ff == vc_ff};
         CMD_GT:   alu_res = {15'd0, vb_ff > vc_ff};
         CMD_ADD:  alu_res = {1'b0, vb_ff[14:0] + vc_ff[14:0]};
         CMD_MULT: alu_res = {1'b0, prod[14:0]};
         CMD_AND:  alu_res = vb_ff & vc_ff;
         CMD_OR:   alu_res = vb_ff | vc_ff;
         CMD_NOT:  alu_res = {1'b0, ~vb_ff[14:0]};
         default:  alu_res = vb_ff;
      endcase
   end

   always_comb begin
      unique case (cmd_i.res_sel)
         RES_ALU:   res = alu_res;
         RES_MOD:   res = mod_rem;
         RES_STACK: res = stk_q_ff;
         RES_MEM:   res = mem_q_ok_ff ? mem_q_ff : 16'd0;
         RES_CHAR:  res = {8'd0, ch_ff};
         default:   res = vb_ff;
      endcase
   end

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= '0;
      end else if (cmd_i.wr_dest && a_ff >= OP_REG_BASE) begin
         regs_ff[a_ff[2:0]] <= res;
      end
   end

   // Word memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd_i.wr_dest && a_ff < OP_REG_BASE && {1'b0, a_ff} < 17'(MEM_WORDS)) begin
         mem[a_ff[MAW-1:0]] <= res;
      end else if (cmd_i.mem_wr_a && {1'b0, va_ff} < 17'(MEM_WORDS)) begin
         mem[va_ff[MAW-1:0]] <= vb_ff;
      end
      if (cmd_i.mem_rd) begin
         mem_q_ff    <= mem[vb_ff[MAW-1:0]];
         mem_q_ok_ff <= {1'b0, vb_ff} < 17'(MEM_WORDS);
      end
   end

   // Return stack and its pointer.
   always_ff @(posedge clock) begin
      if (cmd_i.stk_push) begin
         stk[sp_ff[SAW-1:0]] <= cmd_i.push_ra ? {1'b0, ra_ff} : va_ff;
      end
      if (cmd_i.stk_rd) begin
         stk_q_ff <= stk[SAW'(sp_ff - SPW'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else if (cmd_i.stk_push) begin
         sp_ff <= sp_ff + SPW'(1);
      end else if (cmd_i.stk_pop) begin
         sp_ff <= sp_ff - SPW'(1);
      end
   end

   always_comb begin
      stat_o.cmd        = cmd_ff;
      stat_o.bad_a      = is_bad(a_ff);
      stat_o.bad_b      = is_bad(b_ff);
      stat_o.bad_c      = is_bad(c_ff);
      stat_o.a_is_reg   = a_ff >= OP_REG_BASE;
      stat_o.stk_empty  = sp_ff == '0;
      stat_o.stk_full   = sp_ff >= SPW'(STACK_DEPTH);
      stat_o.vc_zero    = vc_ff == '0;
      stat_o.va_nonzero = va_ff != '0;
      stat_o.mod_done   = mod_done;
      stat_o.va_low     = va_ff[14:0];
      stat_o.vb_low     = vb_ff[14:0];
      stat_o.stk_low    = stk_q_ff[14:0];
   end

endmodule
`default_nettype wire

// File: design/svm_control.sv
// Controller: sequences each instruction and builds the result beat.
`default_nettype none
module svm_control
   import svm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,
   output svm_cmd_type       cmd_o,
   input  wire svm_stat_type stat_i
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_MOD  = 3'd3;
   localparam logic [2:0] S_WB   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        vld_ff, vld_in;
   logic [2:0]  st_ff, st_in;
   logic        rd_ff, rd_in;
   logic [14:0] tg_ff, tg_in;
   logic        cv_ff, cv_in;
   logic [7:0]  co_ff, co_in;
   logic        fin;
   logic        bad3;

   assign bad3 = stat_i.bad_a | stat_i.bad_b | stat_i.bad_c;

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff;
      st_in    = st_ff;
      rd_in    = rd_ff;
      tg_in    = tg_ff;
      cv_in    = cv_ff;
      co_in    = co_ff;
      cmd_o    = '0;
      fin      = 1'b0;
      req_tready = (state_ff == S_IDLE) && !vld_ff;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_o.load = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd_o.op_rd = 1'b1;
            st_in = ST_OK; rd_in = 1'b0; tg_in = '0; cv_in = 1'b0; co_in = '0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_WB;
            unique case (stat_i.cmd)
               CMD_SET: begin
                  if (!stat_i.a_is_reg || stat_i.bad_a || stat_i.bad_b) st_in = ST_BAD_OP;
                  else begin cmd_o.wr_dest = 1'b1; cmd_o.res_sel = RES_VB; end
                  fin = 1'b1;
               end
               CMD_PUSH: begin
                  if (stat_i.bad_a) st_in = ST_BAD_OP;
                  else if (stat_i.stk_full) st_in = ST_STK_FULL;
                  else cmd_o.stk_push = 1'b1;
                  fin = 1'b1;
               end
               CMD_POP, CMD_RET: begin
                  if (stat_i.cmd == CMD_POP && stat_i.bad_a) begin
                     st_in = ST_BAD_OP; fin = 1'b1;
                  end else if (stat_i.stk_empty) begin
                     st_in = ST_STK_EMPTY; fin = 1'b1;
                  end else cmd_o.stk_rd = 1'b1;
               end
               CMD_EQ, CMD_GT, CMD_ADD, CMD_MULT, CMD_AND, CMD_OR: begin
                  if (bad3) st_in = ST_BAD_OP;
                  else begin cmd_o.wr_dest = 1'b1; cmd_o.res_sel = RES_ALU; end
                  fin = 1'b1;
               end
               CMD_MOD: begin
                  if (bad3) begin st_in = ST_BAD_OP; fin = 1'b1; end
                  else if (stat_i.vc_zero) begin st_in = ST_DIV_ZERO; fin = 1'b1; end
                  else begin cmd_o.mod_start = 1'b1; state_in = S_MOD; end
               end
               CMD_NOT: begin
                  if (stat_i.bad_a || stat_i.bad_b) st_in = ST_BAD_OP;
                  else begin cmd_o.wr_dest = 1'b1; cmd_o.res_sel = RES_ALU; end
                  fin = 1'b1;
               end
               CMD_JMP: begin
                  if (stat_i.bad_a) st_in = ST_BAD_OP;
                  else begin rd_in = 1'b1; tg_in = stat_i.va_low; end
                  fin = 1'b1;
               end
               CMD_JT, CMD_JF: begin
                  if (stat_i.bad_a) st_in = ST_BAD_OP;
                  else if ((stat_i.cmd == CMD_JT) == stat_i.va_nonzero) begin
                     if (stat_i.bad_b) st_in = ST_BAD_OP;
                     else begin rd_in = 1'b1; tg_in = stat_i.vb_low; end
                  end
                  fin = 1'b1;
               end
               CMD_RMEM: begin
                  if (stat_i.bad_a || stat_i.bad_b) begin st_in = ST_BAD_OP; fin = 1'b1; end
                  else cmd_o.mem_rd = 1'b1;
               end
               CMD_WMEM: begin
                  if (stat_i.bad_a || stat_i.bad_b) st_in = ST_BAD_OP;
                  else cmd_o.mem_wr_a = 1'b1;
                  fin = 1'b1;
               end
               CMD_CALL: begin
                  if (stat_i.bad_a) st_in = ST_BAD_OP;
                  else if (stat_i.stk_full) st_in = ST_STK_FULL;
                  else begin
                     cmd_o.stk_push = 1'b1; cmd_o.push_ra = 1'b1;
                     rd_in = 1'b1; tg_in = stat_i.va_low;
                  end
                  fin = 1'b1;
               end
               CMD_OUT: begin
                  if (stat_i.bad_a) st_in = ST_BAD_OP;
                  else begin cv_in = 1'b1; co_in = stat_i.va_low[7:0]; end
                  fin = 1'b1;
               end
               CMD_IN: begin
                  if (stat_i.bad_a) st_in = ST_BAD_OP;
                  else begin cmd_o.wr_dest = 1'b1; cmd_o.res_sel = RES_CHAR; end
                  fin = 1'b1;
               end
               default: fin = 1'b1;
            endcase
            if (fin) begin
               state_in = S_IDLE;
               vld_in   = 1'b1;
            end
         end
         S_MOD: begin
            if (stat_i.mod_done) begin
               cmd_o.wr_dest = 1'b1; cmd_o.res_sel = RES_MOD;
               state_in = S_IDLE; vld_in = 1'b1;
            end
         end
         S_WB: begin
            // Stack or memory read data is ready; finish pop, ret or rmem.
            unique case (stat_i.cmd)
               CMD_POP: begin
                  cmd_o.stk_pop = 1'b1; cmd_o.wr_dest = 1'b1; cmd_o.res_sel = RES_STACK;
               end
               CMD_RET: begin
                  cmd_o.stk_pop = 1'b1; rd_in = 1'b1; tg_in = stat_i.stk_low;
               end
               default: begin
                  cmd_o.wr_dest = 1'b1; cmd_o.res_sel = RES_MEM;
               end
            endcase
            state_in = S_IDLE; vld_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      rd_ff <= rd_in;
      tg_ff <= tg_in;
      cv_ff <= cv_in;
      co_ff <= co_in;
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {4'd0, co_ff, cv_ff, tg_ff, rd_ff, st_ff};

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench of the stack machine execute unit, with scoreboard.

// Predicts each result of the execute unit from its own copy of the machine state.
class exec_scoreboard;
   typedef struct {
      logic [2:0]  status;
      logic        redirect;
      logic [14:0] target;
      logic        char_valid;
      logic [7:0]  char_out;
   } exec_result_type;

   logic [15:0]     regs [8];
   logic [15:0]     mem [32768];
   bit              written [32768];
   int              written_addrs [$];
   logic [15:0]     stk [256];
   int              sp;
   exec_result_type expected_q [$];
   int              errors;

   function new();
      foreach (regs[i]) regs[i] = '0;
      sp = 0;
      errors = 0;
   endfunction

   function logic [15:0] value_of(logic [15:0] x);
      return (x < svm_pkg::OP_REG_BASE) ? x : regs[x[2:0]];
   endfunction

   function bit bad(logic [15:0] x);
      return x > svm_pkg::OP_REG_LAST;
   endfunction

   // A memory read is legal beyond the memory or at a written word.
   function bit readable(logic [15:0] v);
      return v >= 16'd32768 || written[v[14:0]];
   endfunction

   function void mem_store(logic [15:0] addr, logic [15:0] v);
      if (addr < 16'd32768) begin
         mem[addr[14:0]] = v;
         if (!written[addr[14:0]]) begin
            written[addr[14:0]] = 1;
            written_addrs.push_back(addr);
         end
      end
   endfunction

   function void dest_store(logic [15:0] d, logic [15:0] v);
      if (d >= svm_pkg::OP_REG_BASE) regs[d[2:0]] = v;
      else mem_store(d, v);
   endfunction

   // Executes one accepted instruction and queues its expected result.
   function void note_input(logic [4:0] cmd, logic [15:0] a, logic [15:0] b,
                            logic [15:0] c, logic [14:0] ra, logic [7:0] ch);
      exec_result_type e;
      logic [15:0] vb, vc, r, v;
      e = '{svm_pkg::ST_OK, 1'b0, 15'd0, 1'b0, 8'd0};
      case (cmd)
         svm_pkg::CMD_SET: begin
            if (a < svm_pkg::OP_REG_BASE || bad(a) || bad(b)) e.status = svm_pkg::ST_BAD_OP;
            else regs[a[2:0]] = value_of(b);
         end
         svm_pkg::CMD_PUSH: begin
            if (bad(a)) e.status = svm_pkg::ST_BAD_OP;
            else if (sp >= 256) e.status = svm_pkg::ST_STK_FULL;
            else begin
               stk[sp] = value_of(a);
               sp++;
            end
         end
         svm_pkg::CMD_POP: begin
            if (bad(a)) e.status = svm_pkg::ST_BAD_OP;
            else if (sp == 0) e.status = svm_pkg::ST_STK_EMPTY;
            else begin
               sp--;
               dest_store(a, stk[sp]);
            end
         end
         svm_pkg::CMD_EQ, svm_pkg::CMD_GT, svm_pkg::CMD_ADD, svm_pkg::CMD_MULT,
         svm_pkg::CMD_MOD, svm_pkg::CMD_AND, svm_pkg::CMD_OR: begin
            if (bad(a) || bad(b) || bad(c)) e.status = svm_pkg::ST_BAD_OP;
            else begin
               vb = value_of(b);
               vc = value_of(c);
               case (cmd)
                  svm_pkg::CMD_EQ:   r = (vb == vc) ? 16'd1 : 16'd0;
                  svm_pkg::CMD_GT:   r = (vb > vc) ? 16'd1 : 16'd0;
                  svm_pkg::CMD_ADD:  r = {1'b0, 15'(vb + vc)};
                  svm_pkg::CMD_MULT: r = {1'b0, 15'(32'(vb) * 32'(vc))};
                  svm_pkg::CMD_MOD:  r = (vc == 0) ? 16'd0 : vb % vc;
                  svm_pkg::CMD_AND:  r = vb & vc;
                  default:           r = vb | vc;
               endcase
               if (cmd == svm_pkg::CMD_MOD && vc == 0) e.status = svm_pkg::ST_DIV_ZERO;
               else dest_store(a, r);
            end
         end
         svm_pkg::CMD_JMP: begin
            if (bad(a)) e.status = svm_pkg::ST_BAD_OP;
            else begin
               v = value_of(a);
               e.redirect = 1;
               e.target = v[14:0];
            end
         end
         svm_pkg::CMD_JT, svm_pkg::CMD_JF: begin
            if (bad(a)) e.status = svm_pkg::ST_BAD_OP;
            else if ((cmd == svm_pkg::CMD_JT) == (value_of(a) != 0)) begin
               // The jump target only matters when the jump is taken.
               if (bad(b)) e.status = svm_pkg::ST_BAD_OP;
               else begin
                  v = value_of(b);
                  e.redirect = 1;
                  e.target = v[14:0];
               end
            end
         end
         svm_pkg::CMD_NOT: begin
            if (bad(a) || bad(b)) e.status = svm_pkg::ST_BAD_OP;
            else begin
               v = value_of(b);
               dest_store(a, {1'b0, ~v[14:0]});
            end
         end
         svm_pkg::CMD_RMEM: begin
            if (bad(a) || bad(b)) e.status = svm_pkg::ST_BAD_OP;
            else begin
               v = value_of(b);
               dest_store(a, (v < 16'd32768) ? mem[v[14:0]] : 16'd0);
            end
         end
         svm_pkg::CMD_WMEM: begin
            if (bad(a) || bad(b)) e.status = svm_pkg::ST_BAD_OP;
            else mem_store(value_of(a), value_of(b));
         end
         svm_pkg::CMD_CALL: begin
            if (bad(a)) e.status = svm_pkg::ST_BAD_OP;
            else if (sp >= 256) e.status = svm_pkg::ST_STK_FULL;
            else begin
               stk[sp] = {1'b0, ra};
               sp++;
               v = value_of(a);
               e.redirect = 1;
               e.target = v[14:0];
            end
         end
         svm_pkg::CMD_RET: begin
            if (sp == 0) e.status = svm_pkg::ST_STK_EMPTY;
            else begin
               sp--;
               e.redirect = 1;
               e.target = stk[sp][14:0];
            end
         end
         svm_pkg::CMD_OUT: begin
            if (bad(a)) e.status = svm_pkg::ST_BAD_OP;
            else begin
               v = value_of(a);
               e.char_valid = 1;
               e.char_out = v[7:0];
            end
         end
         svm_pkg::CMD_IN: begin
            if (bad(a)) e.status = svm_pkg::ST_BAD_OP;
            else dest_store(a, {8'd0, ch});
         end
         default: ;
      endcase
      expected_q.push_back(e);
   endfunction

   // Compares one result beat with the oldest expectation.
   function void check_result(logic [31:0] d);
      exec_result_type e;
      if (expected_q.size() == 0) begin
         $error("result beat 0x%08h arrived with nothing expected", d);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (d[2:0] !== e.status) begin
         $error("status expected %0d got %0d", e.status, d[2:0]);
         errors++;
      end
      if (d[3] !== e.redirect) begin
         $error("redirect expected %0d got %0d", e.redirect, d[3]);
         errors++;
      end
      if (d[18:4] !== e.target) begin
         $error("redirect_target expected %0d got %0d", e.target, d[18:4]);
         errors++;
      end
      if (d[19] !== e.char_valid) begin
         $error("char_valid expected %0d got %0d", e.char_valid, d[19]);
         errors++;
      end
      if (d[27:20] !== e.char_out) begin
         $error("char_out expected %0d got %0d", e.char_out, d[27:20]);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import svm_pkg::*;

   localparam int PHASE_ITEMS = 480;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold_left = 0;
   int mode = 0;  // 0 mixed, 1 stack filling, 2 stack draining

   exec_scoreboard sb = new();

   stack_vm_instruction_execute DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (rx_hold_left > 0) begin
         rsp_tready <= 0;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Random operand: mostly registers and literals, a few invalid values.
   function automatic logic [15:0] rand_operand();
      int p;
      p = $urandom_range(99);
      if (p < 8) return 16'($urandom_range(32776, 65535));
      if (p < 45) return 16'(32768 + $urandom_range(7));
      if (p < 58) begin
         case ($urandom_range(2))
            0: return 16'd0;
            1: return 16'd1;
            default: return 16'd32767;
         endcase
      end
      return 16'($urandom_range(32767));
   endfunction

   // Sends one instruction beat and records it once it is accepted.
   task automatic send_instr(logic [4:0] cmd, logic [15:0] a, logic [15:0] b,
                             logic [15:0] c, logic [14:0] ra, logic [7:0] ch);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, ch, ra, c, b, a, cmd};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_input(cmd, a, b, c, ra, ch);
   endtask

   // Builds one random instruction, biased by the current stack mode.
   task automatic send_random();
      logic [4:0]  cmd;
      logic [15:0] a, b, c;
      int p, tries;
      p = $urandom_range(99);
      if (mode == 1 && p < 90) cmd = ($urandom_range(3) == 0) ? CMD_CALL : CMD_PUSH;
      else if (mode == 2 && p < 90) cmd = ($urandom_range(3) == 0) ? CMD_RET : CMD_POP;
      else if (p < 3) cmd = 5'($urandom_range(20, 31));
      else cmd = 5'($urandom_range(CMD_IN));
      a = rand_operand();
      b = rand_operand();
      c = rand_operand();
      if (cmd == CMD_SET && $urandom_range(99) < 85) a = 16'(32768 + $urandom_range(7));
      if (cmd == CMD_MOD && $urandom_range(99) < 70 && c < 16'd32768 && c == 0)
         c = 16'($urandom_range(1, 32767));
      // A read of a never-written memory word must not be caused.
      if (cmd == CMD_RMEM && !sb.bad(a)) begin
         tries = 0;
         while (!sb.bad(b) && !sb.readable(sb.value_of(b)) && tries < 8) begin
            if (sb.written_addrs.size() > 0 && $urandom_range(1))
               b = 16'(sb.written_addrs[$urandom_range(sb.written_addrs.size() - 1)]);
            else
               b = rand_operand();
            tries++;
         end
         if (!sb.bad(b) && !sb.readable(sb.value_of(b))) cmd = CMD_WMEM;
      end
      send_instr(cmd, a, b, c, 15'($urandom), 8'($urandom));
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Main sequence: directed cases, then three phases of random beats, the first two with idling.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Wrap-around, divide by zero and the logic operations.
      send_instr(CMD_SET, 16'd32768, 16'd32767, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_ADD, 16'd32769, 16'd32768, 16'd1, 15'd0, 8'd0);
      send_instr(CMD_MULT, 16'd32770, 16'd32768, 16'd32768, 15'd0, 8'd0);
      send_instr(CMD_MOD, 16'd32771, 16'd32768, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_MOD, 16'd32771, 16'd100, 16'd7, 15'd0, 8'd0);
      send_instr(CMD_EQ, 16'd32772, 16'd32768, 16'd32767, 15'd0, 8'd0);
      send_instr(CMD_GT, 16'd32772, 16'd0, 16'd32767, 15'd0, 8'd0);
      send_instr(CMD_AND, 16'd32773, 16'd32768, 16'd21845, 15'd0, 8'd0);
      send_instr(CMD_OR, 16'd32773, 16'd0, 16'd32767, 15'd0, 8'd0);
      send_instr(CMD_NOT, 16'd32773, 16'd0, 16'd0, 15'd0, 8'd0);
      // Memory at both ends, a literal destination and an invalid operand.
      send_instr(CMD_WMEM, 16'd0, 16'd32768, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_WMEM, 16'd32767, 16'd5, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_RMEM, 16'd32774, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_RMEM, 16'd32775, 16'd32768, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_WMEM, 16'd0, 16'd65535, 16'd0, 15'd0, 8'd0);
      // Stack: push, pop with an invalid operand, pop to memory, pop and return on an empty stack, call and return.
      send_instr(CMD_PUSH, 16'd32775, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_POP, 16'd65535, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_POP, 16'd100, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_POP, 16'd32774, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_RET, 16'd0, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_CALL, 16'd32768, 16'd0, 16'd0, 15'd32767, 8'd0);
      send_instr(CMD_RET, 16'd0, 16'd0, 16'd0, 15'd0, 8'd0);
      // Jumps taken and not taken, with an invalid target.
      send_instr(CMD_JMP, 16'd32775, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_JT, 16'd0, 16'd65535, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_JT, 16'd32768, 16'd65535, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_JF, 16'd0, 16'd0, 16'd0, 15'd0, 8'd0);
      // Console, a set to a literal and an unknown code.
      send_instr(CMD_OUT, 16'd32768, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_IN, 16'd32774, 16'd0, 16'd0, 15'd0, 8'd255);
      send_instr(CMD_IN, 16'd65535, 16'd0, 16'd0, 15'd0, 8'd0);
      send_instr(CMD_SET, 16'd5, 16'd1, 16'd0, 15'd0, 8'd0);
      send_instr(5'd31, 16'd65535, 16'd65535, 16'd65535, 15'd32767, 8'd255);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 78 : 0;
         rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 26 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Bias towards filling the stack and then draining it in the last phase.
            if (phase == 2) mode = (i < 100) ? 0 : (i < 380) ? 1 : 2;
            else mode = 0;
            if (phase == 1 && i == 200) rx_hold_left = 300;
            if (i == PHASE_ITEMS / 2) drain_results();
            send_random();
         end
         drain_results();
      end

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #30000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
